// ===== rtl/mpsm_pkg.sv =====
`timescale 1ns / 1ps
// package: shared types, opcodes and defaults of the multivoice pcm mixer
package mpsm_pkg;

    localparam int VOICES_DEF        = 24;
    localparam int ROM_ADDR_BITS_DEF = 20;
    localparam int REG_AW            = 9;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [3:0] REG_MODE = 4'd5;
    localparam logic [3:0] REG_BANK = 4'd4;
    localparam logic [8:0] REG_VOICE_LIMIT = 9'h180;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [19:0] address;
        logic [7:0]  write_data;
    } req_word_t;

    typedef struct packed {
        logic [7:0]         read_data;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0]        phase;
        logic signed [17:0] pos;
        logic signed [11:0] newest;
        logic signed [11:0] older;
        logic signed [12:0] step;
        logic [7:0]         bank;
        logic               shift_mode;
        logic               loop_mode;
        logic [15:0]        start_addr;
        logic [15:0]        stop_addr;
        logic [15:0]        loop_addr;
    } voice_t;

endpackage

// ===== rtl/mpsm_req_if.sv =====
`timescale 1ns / 1ps
// interfaces: request and response channels of the pcm mixer
interface mpsm_req_if;
    import mpsm_pkg::*;
    logic      valid;
    logic      ready;
    req_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mpsm_rsp_if;
    import mpsm_pkg::*;
    logic      valid;
    logic      ready;
    rsp_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/mpsm_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
module mpsm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/multivoice_pcm_sample_mixer_unit.sv =====
`timescale 1ns / 1ps
// top level: multivoice pcm sample mixer
//
// req carries one word per operation: register write, register read, sample
// rom byte load or tick. rsp returns exactly one word per request, in order.
// A write or a rom load answers in the next cycle with an all-zero word. A read
// answers with the register byte: the registered ram read lands in S_READ and
// then moves into the output register. A write with bit 7 set to a voice mode
// register keys the voice on and keeps the block busy: nine reads of the voice
// registers out of the register ram, one byte per cycle, then the voice ram
// write. A tick walks the voices in turn: one that is not keyed is only selected
// and stepped; a keyed one takes four register ram reads and a voice ram read,
// then, unless its frequency is zero or it ends, a rom read, the interpolation
// multiply and two volume multiplies; the serial voice walk sets the rate.
// One request is in flight at a time; req.ready is low while a result waits
// in the output register, so a stalled receiver stalls the block.
// After reset the register ram is swept to zero, entry by entry, with req.ready
// low. The sample rom is not cleared; voice state is only read once keyed.
module multivoice_pcm_sample_mixer_unit #(
    parameter int VOICES        = mpsm_pkg::VOICES_DEF,
    parameter int ROM_ADDR_BITS = mpsm_pkg::ROM_ADDR_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    mpsm_req_if.sink   req,
    mpsm_rsp_if.source rsp
);
    import mpsm_pkg::*;

    localparam int VAW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VW     = $bits(voice_t);
    localparam int VOL_K  = 19;
    localparam logic [19:0] VOL_M = 20'(((1 << VOL_K) + VOICES - 1) / VOICES);
    localparam int FIFTH_K = 17;
    localparam logic [14:0] FIFTH_M = 15'(((1 << FIFTH_K) + 4) / 5);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_KEY   = 4'd3;
    localparam logic [3:0] S_KEYW  = 4'd4;
    localparam logic [3:0] S_VSEL  = 4'd5;
    localparam logic [3:0] S_VREG  = 4'd6;
    localparam logic [3:0] S_VCALC = 4'd7;
    localparam logic [3:0] S_VROM  = 4'd8;
    localparam logic [3:0] S_VMUL  = 4'd9;
    localparam logic [3:0] S_VDT   = 4'd10;
    localparam logic [3:0] S_VL    = 4'd11;
    localparam logic [3:0] S_VR    = 4'd12;
    localparam logic [3:0] S_VACC  = 4'd13;
    localparam logic [3:0] S_VSTEP = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    // control registers
    logic [3:0]        state_reg, state_next;
    logic [8:0]        clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic [VOICES-1:0] keyed_reg, keyed_next;
    logic [VAW-1:0]    v_reg, v_next;
    logic [VAW-1:0]    kv_reg, kv_next;
    logic [3:0]        c_reg, c_next;

    // payload registers
    rsp_word_t          out_reg, out_next;
    logic [1:0]         kmode_reg, kmode_next;
    logic [63:0]        sh_reg, sh_next;
    voice_t             vw_reg, vw_next;
    logic [7:0]         volr_reg, volr_next;
    logic [7:0]         voll_reg, voll_next;
    logic [7:0]         fhi_reg, fhi_next;
    logic [7:0]         flo_reg, flo_next;
    logic [12:0]        lvq_reg, lvq_next;
    logic [12:0]        rvq_reg, rvq_next;
    logic [14:0]        lvol_reg, lvol_next;
    logic [14:0]        rvol_reg, rvol_next;
    logic               fetch_reg, fetch_next;
    logic signed [29:0] prod_reg, prod_next;
    logic signed [13:0] dt_reg, dt_next;
    logic signed [29:0] lprod_reg, lprod_next;
    logic signed [29:0] rprod_reg, rprod_next;
    logic [15:0]        lmix_reg, lmix_next;
    logic [15:0]        rmix_reg, rmix_next;

    // memories
    logic                     reg_we;
    logic [REG_AW-1:0]        reg_waddr, reg_raddr;
    logic [7:0]               reg_wdata, reg_rdata;
    logic                     vram_we;
    logic [VAW-1:0]           vram_waddr;
    voice_t                   vram_wdata, vram_rdata;
    logic [VW-1:0]            vram_rdata_raw;
    logic                     rom_we;
    logic [ROM_ADDR_BITS-1:0] rom_waddr, rom_raddr;
    logic [7:0]               rom_rdata;

    mpsm_ram #(.WIDTH(8), .DEPTH(512), .ADDR_W(REG_AW)) u_reg_ram (
        .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
        .raddr(reg_raddr), .rdata(reg_rdata)
    );

    mpsm_ram #(.WIDTH(VW), .DEPTH(VOICES), .ADDR_W(VAW)) u_voice_ram (
        .clk(clk), .we(vram_we), .waddr(vram_waddr), .wdata(vram_wdata),
        .raddr(v_reg), .rdata(vram_rdata_raw)
    );
    assign vram_rdata = vram_rdata_raw;

    mpsm_ram #(.WIDTH(8), .DEPTH(1 << ROM_ADDR_BITS), .ADDR_W(ROM_ADDR_BITS)) u_rom (
        .clk(clk), .we(rom_we), .waddr(rom_waddr), .wdata(req.payload.write_data),
        .raddr(rom_raddr), .rdata(rom_rdata)
    );

    function automatic logic [15:0] sat8(input logic [15:0] m);
        logic signed [18:0] s;
        logic [15:0]        r;
        begin
            s = $signed({{3{m[15]}}, m}) <<< 3;
            if (s > 19'sd32767)
                r = 16'h7fff;
            else if (s < -19'sd32768)
                r = 16'h8000;
            else
                r = s[15:0];
            return r;
        end
    endfunction

    // decode of the incoming word
    logic              accept;
    logic [8:0]        off;
    logic              key_reg_hit;
    logic [8:0]        vbase, kbase;
    assign accept      = req.valid && req.ready;
    assign off         = req.payload.address[8:0];
    assign key_reg_hit = (off < REG_VOICE_LIMIT) && (off[3:0] == REG_MODE)
                         && (32'(off[8:4]) < VOICES);
    assign vbase       = 9'(v_reg) << 4;
    assign kbase       = 9'(kv_reg) << 4;
    assign req.ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // voice advance, computed from the registers read out of the rams
    logic [15:0]        freq;
    logic [17:0]        psum;
    logic [1:0]         cnt;
    logic signed [17:0] pos_inc, loop_pos;
    logic signed [16:0] size;
    logic               at_end;
    logic [23:0]        adrs;
    logic [19:0]        base;
    voice_t             adv;
    logic [32:0]        lq_prod, rq_prod;
    logic [13:0]        l2, r2;
    logic [28:0]        lf_prod, rf_prod;
    logic signed [7:0]  rb;
    logic signed [11:0] sval, bval;
    voice_t             key_word;

    always_comb
    begin
        freq     = {fhi_reg, flo_reg};
        psum     = {2'b00, vw_reg.phase} + {1'b0, freq, 1'b0};
        cnt      = psum[17:16];
        pos_inc  = vw_reg.pos + $signed({16'b0, cnt});
        size     = $signed({1'b0, vw_reg.stop_addr}) - $signed({1'b0, vw_reg.start_addr});
        loop_pos = $signed({2'b00, vw_reg.loop_addr}) - $signed({2'b00, vw_reg.start_addr});
        at_end   = $signed({pos_inc[17], pos_inc}) >= $signed({{2{size[16]}}, size});
        adv       = vw_reg;
        adv.phase = psum[15:0];
        adv.pos   = (at_end && vw_reg.loop_mode) ? loop_pos : pos_inc;
        adrs      = {vw_reg.bank, 16'b0} + {8'b0, vw_reg.start_addr};
        base      = {adrs[21], adrs[18:0]};
        rom_raddr = ROM_ADDR_BITS'(base + 20'($signed(adv.pos)));
        lq_prod   = {voll_reg, 5'b0} * VOL_M;
        rq_prod   = {volr_reg, 5'b0} * VOL_M;
        // x*12/5 taken as 2x + 2x/5
        l2        = {lvq_reg, 1'b0};
        r2        = {rvq_reg, 1'b0};
        lf_prod   = l2 * FIFTH_M;
        rf_prod   = r2 * FIFTH_M;
        rb        = $signed(rom_rdata);
        bval      = {{4{rb[7]}}, rb};
        sval      = (bval >>> 3) <<< rb[2:0];
        key_word            = '0;
        key_word.bank       = sh_reg[63:56];
        key_word.shift_mode = kmode_reg[0];
        key_word.loop_mode  = kmode_reg[1];
        key_word.start_addr = sh_reg[47:32];
        key_word.stop_addr  = sh_reg[31:16];
        key_word.loop_addr  = sh_reg[15:0];
    end

    // memory port control
    always_comb
    begin
        reg_we    = 1'b0;
        reg_waddr = off;
        reg_wdata = req.payload.write_data;
        if (state_reg == S_CLEAR)
        begin
            reg_we    = 1'b1;
            reg_waddr = clr_reg;
            reg_wdata = 8'h00;
        end
        else if (accept && req.payload.opcode == OP_WRITE)
        begin
            reg_we = 1'b1;
        end
        case (state_reg)
            S_KEY:   reg_raddr = kbase + 9'(REG_BANK) + 9'(c_reg);
            S_VREG:  reg_raddr = vbase + 9'(c_reg);
            default: reg_raddr = off;
        endcase
        rom_we    = accept && req.payload.opcode == OP_LOAD;
        rom_waddr = req.payload.address[ROM_ADDR_BITS-1:0];
        vram_we    = 1'b0;
        vram_waddr = v_reg;
        vram_wdata = vw_reg;
        case (state_reg)
            S_KEYW:
            begin
                vram_we    = 1'b1;
                vram_waddr = kv_reg;
                vram_wdata = key_word;
            end
            S_VCALC:
            begin
                vram_we    = (freq != 16'h0) && at_end && !vw_reg.loop_mode;
                vram_wdata = adv;
            end
            S_VDT:   vram_we = 1'b1;
            default: vram_we = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        keyed_next     = keyed_reg;
        v_next         = v_reg;
        kv_next        = kv_reg;
        c_next         = c_reg;
        out_next       = out_reg;
        kmode_next     = kmode_reg;
        sh_next        = sh_reg;
        vw_next        = vw_reg;
        volr_next      = volr_reg;
        voll_next      = voll_reg;
        fhi_next       = fhi_reg;
        flo_next       = flo_reg;
        lvq_next       = lvq_reg;
        rvq_next       = rvq_reg;
        lvol_next      = lvol_reg;
        rvol_next      = rvol_reg;
        fetch_next     = fetch_reg;
        prod_next      = prod_reg;
        dt_next        = dt_reg;
        lprod_next     = lprod_reg;
        rprod_next     = rprod_reg;
        lmix_next      = lmix_reg;
        rmix_next      = rmix_reg;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 9'd1;
                if (clr_reg == 9'h1ff)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next = '0;
                    c_next   = 4'd0;
                    case (req.payload.opcode)
                        OP_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            if (key_reg_hit)
                            begin
                                kv_next = VAW'(off[8:4]);
                                if (req.payload.write_data[7])
                                begin
                                    keyed_next[off[8:4]] = 1'b1;
                                    kmode_next = {req.payload.write_data[4],
                                                  req.payload.write_data[3]};
                                    state_next = S_KEY;
                                end
                                else
                                begin
                                    keyed_next[off[8:4]] = 1'b0;
                                end
                            end
                        end
                        OP_READ: state_next = S_READ;
                        OP_LOAD: out_valid_next = 1'b1;
                        default:
                        begin
                            v_next     = '0;
                            lmix_next  = 16'h0;
                            rmix_next  = 16'h0;
                            state_next = S_VSEL;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_next.read_data = reg_rdata;
                out_valid_next     = 1'b1;
                state_next         = S_IDLE;
            end
            S_KEY:
            begin
                // bytes bank through loop lsb arrive one per cycle
                if (c_reg != 4'd0)
                    sh_next = {sh_reg[55:0], reg_rdata};
                if (c_reg == 4'd8)
                    state_next = S_KEYW;
                else
                    c_next = c_reg + 4'd1;
            end
            S_KEYW: state_next = S_IDLE;
            S_VSEL:
            begin
                c_next = 4'd0;
                if (keyed_reg[v_reg])
                    state_next = S_VREG;
                else
                    state_next = S_VSTEP;
            end
            S_VREG:
            begin
                case (c_reg)
                    4'd1:
                    begin
                        vw_next   = vram_rdata;
                        volr_next = reg_rdata;
                    end
                    4'd2:    voll_next = reg_rdata;
                    4'd3:    fhi_next  = reg_rdata;
                    4'd4:    flo_next  = reg_rdata;
                    default: fhi_next  = fhi_reg;
                endcase
                if (c_reg == 4'd4)
                    state_next = S_VCALC;
                else
                    c_next = c_reg + 4'd1;
            end
            S_VCALC:
            begin
                if (freq == 16'h0)
                begin
                    state_next = S_VSTEP;
                end
                else
                begin
                    vw_next    = adv;
                    lvq_next   = 13'(lq_prod >> VOL_K);
                    rvq_next   = 13'(rq_prod >> VOL_K);
                    fetch_next = vw_reg.shift_mode || (cnt != 2'd0);
                    if (at_end && !vw_reg.loop_mode)
                    begin
                        keyed_next[v_reg] = 1'b0;
                        state_next        = S_VSTEP;
                    end
                    else
                    begin
                        state_next = S_VROM;
                    end
                end
            end
            S_VROM:
            begin
                if (vw_reg.shift_mode)
                begin
                    lvol_next = 15'(l2) + 15'(lf_prod >> FIFTH_K);
                    rvol_next = 15'(r2) + 15'(rf_prod >> FIFTH_K);
                end
                else
                begin
                    lvol_next = 15'(lvq_reg);
                    rvol_next = 15'(rvq_reg);
                end
                if (fetch_reg)
                begin
                    vw_next.older  = vw_reg.newest;
                    vw_next.newest = vw_reg.shift_mode ? sval : bval;
                    vw_next.step   = $signed({(vw_reg.shift_mode ? sval[11] : bval[11]),
                                              (vw_reg.shift_mode ? sval : bval)})
                                     - $signed({vw_reg.newest[11], vw_reg.newest});
                end
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                prod_next  = 30'(vw_reg.step * $signed({1'b0, vw_reg.phase}));
                state_next = S_VDT;
            end
            S_VDT:
            begin
                dt_next    = 14'(prod_reg >>> 16) + 14'(vw_reg.older);
                state_next = S_VL;
            end
            S_VL:
            begin
                lprod_next = 30'(dt_reg * $signed({1'b0, lvol_reg}));
                state_next = S_VR;
            end
            S_VR:
            begin
                rprod_next = 30'(dt_reg * $signed({1'b0, rvol_reg}));
                lmix_next  = lmix_reg + 16'(lprod_reg >>> (vw_reg.shift_mode ? 10 : 5));
                state_next = S_VACC;
            end
            S_VACC:
            begin
                rmix_next  = rmix_reg + 16'(rprod_reg >>> (vw_reg.shift_mode ? 10 : 5));
                state_next = S_VSTEP;
            end
            S_VSTEP:
            begin
                if (32'(v_reg) == VOICES - 1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    v_next     = v_reg + VAW'(1);
                    state_next = S_VSEL;
                end
            end
            S_FIN:
            begin
                out_next.read_data    = 8'h00;
                out_next.left_sample  = sat8(lmix_reg);
                out_next.right_sample = sat8(rmix_reg);
                out_valid_next        = 1'b1;
                state_next            = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            keyed_reg     <= '0;
            v_reg         <= '0;
            kv_reg        <= '0;
            c_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            keyed_reg     <= keyed_next;
            v_reg         <= v_next;
            kv_reg        <= kv_next;
            c_reg         <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        kmode_reg <= kmode_next;
        sh_reg    <= sh_next;
        vw_reg    <= vw_next;
        volr_reg  <= volr_next;
        voll_reg  <= voll_next;
        fhi_reg   <= fhi_next;
        flo_reg   <= flo_next;
        lvq_reg   <= lvq_next;
        rvq_reg   <= rvq_next;
        lvol_reg  <= lvol_next;
        rvol_reg  <= rvol_next;
        fetch_reg <= fetch_next;
        prod_reg  <= prod_next;
        dt_reg    <= dt_next;
        lprod_reg <= lprod_next;
        rprod_reg <= rprod_next;
        lmix_reg  <= lmix_next;
        rmix_reg  <= rmix_next;
    end

    // a tick never answers in the cycle after it is taken
    a_tick_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.payload.opcode == OP_TICK) |=> !rsp.valid)
        else $error("tick answered too early");

    // a read word never carries mix samples
    a_read_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.read_data != 8'h00)
        |-> (rsp.payload.left_sample == 16'sh0 && rsp.payload.right_sample == 16'sh0))
        else $error("read word carries samples");

    // voice math only starts after the register and voice reads
    a_calc_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VCALC) |-> ($past(state_reg) == S_VREG && $past(c_reg) == 4'd4))
        else $error("voice calc without its reads");

endmodule

// ===== bench/multivoice_pcm_sample_mixer_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench: multivoice pcm sample mixer against a cycle-free mix predictor
module multivoice_pcm_sample_mixer_unit_tb;
    import mpsm_pkg::*;

    localparam int NUM_VOICES     = VOICES_DEF;
    localparam int ROM_MASK       = (1 << ROM_ADDR_BITS_DEF) - 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 1500;

    typedef struct {
        req_word_t w;
        bit        drain;
    } pending_word_t;

    logic clk;
    logic rst_n;

    mpsm_req_if req ();
    mpsm_rsp_if rsp ();

    multivoice_pcm_sample_mixer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predictor state
    bit [7:0] regs_img [512];
    bit [7:0] rom_img [int];
    bit       v_keyed [NUM_VOICES];
    int       v_phase [NUM_VOICES];
    int       v_pos [NUM_VOICES];
    int       v_new [NUM_VOICES];
    int       v_old [NUM_VOICES];
    int       v_step [NUM_VOICES];
    int       v_bank [NUM_VOICES];
    bit       v_shift [NUM_VOICES];
    bit       v_loop [NUM_VOICES];
    int       v_start [NUM_VOICES];
    int       v_stop [NUM_VOICES];
    int       v_loopa [NUM_VOICES];

    pending_word_t words_to_send [$];
    rsp_word_t     mix_expected [$];

    int  words_queued;
    int  words_accepted;
    int  results_seen;
    int  mismatches;
    int  ticks_sent;
    int  keyons_sent;
    int  saturated_seen;
    int  gap_left;
    int  burst_left;
    int  hold_left;
    bit  hold_done;
    int  ready_cycle;
    int  idle_cycles;
    bit  next_drain;

    function automatic int rom_sample(int a);
        byte sb;
        sb = rom_img.exists(a & ROM_MASK) ? rom_img[a & ROM_MASK] : 8'd0;
        return int'(sb);
    endfunction

    function automatic logic signed [15:0] saturate_x8(bit [15:0] m);
        int s;
        s = int'($signed(m)) * 8;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s[15:0];
    endfunction

    function automatic void voice_advance(int v, ref bit [15:0] lm, ref bit [15:0] rm);
        int r, freq, lvol, rvol, size, adrs, base, phase, cnt, pos, b, s, dt, lc, rc;
        r = v * 16;
        freq = {regs_img[r + 2], regs_img[r + 3]};
        if (freq == 0)
            return;
        lvol = (regs_img[r + 1] * 32) / NUM_VOICES;
        rvol = (regs_img[r] * 32) / NUM_VOICES;
        size = v_stop[v] - v_start[v];
        adrs = (v_bank[v] << 16) + v_start[v];
        base = ((adrs & 'h200000) >> 2) | (adrs & 'h7ffff);
        phase = v_phase[v] + freq * 2;
        cnt = (phase >> 16) & 'h7fff;
        phase = phase & 'hffff;
        pos = v_pos[v] + cnt;
        v_phase[v] = phase;
        if (pos >= size)
        begin
            if (v_loop[v])
                pos = v_loopa[v] - v_start[v];
            else
            begin
                v_keyed[v] = 0;
                v_pos[v] = pos;
                return;
            end
        end
        v_pos[v] = pos;
        if (v_shift[v])
        begin
            b = rom_sample(base + pos);
            s = (b >>> 3) * (1 << (b & 7));
            v_old[v] = v_new[v];
            v_new[v] = s;
            v_step[v] = s - v_old[v];
            lvol = (lvol * 12) / 5;
            rvol = (rvol * 12) / 5;
        end
        else if (cnt != 0)
        begin
            v_old[v] = v_new[v];
            v_new[v] = rom_sample(base + pos);
            v_step[v] = v_new[v] - v_old[v];
        end
        dt = ((v_step[v] * phase) >>> 16) + v_old[v];
        lc = (dt * lvol) >>> (v_shift[v] ? 10 : 5);
        rc = (dt * rvol) >>> (v_shift[v] ? 10 : 5);
        lm = lm + lc[15:0];
        rm = rm + rc[15:0];
    endfunction

    function automatic void mix_predict(req_word_t w);
        rsp_word_t  e;
        int         off, v, r;
        bit [15:0]  lm, rm;
        e = '0;
        lm = '0;
        rm = '0;
        case (w.opcode)
            OP_WRITE:
            begin
                off = w.address[8:0];
                regs_img[off] = w.write_data;
                if (off < REG_VOICE_LIMIT && (off & 15) == REG_MODE && (off >> 4) < NUM_VOICES)
                begin
                    v = off >> 4;
                    r = off & 'h1f0;
                    if (w.write_data[7])
                    begin
                        v_keyed[v] = 1;
                        v_phase[v] = 0;
                        v_pos[v] = 0;
                        v_new[v] = 0;
                        v_old[v] = 0;
                        v_step[v] = 0;
                        v_bank[v] = regs_img[r + REG_BANK];
                        v_shift[v] = w.write_data[3];
                        v_loop[v] = w.write_data[4];
                        v_start[v] = {regs_img[r + 6], regs_img[r + 7]};
                        v_stop[v] = {regs_img[r + 8], regs_img[r + 9]};
                        v_loopa[v] = {regs_img[r + 10], regs_img[r + 11]};
                    end
                    else
                        v_keyed[v] = 0;
                end
            end
            OP_READ:
                e.read_data = regs_img[w.address[8:0]];
            OP_LOAD:
                rom_img[int'(w.address) & ROM_MASK] = w.write_data;
            default:
            begin
                for (int i = 0; i < NUM_VOICES; i++)
                    if (v_keyed[i])
                        voice_advance(i, lm, rm);
                e.left_sample = saturate_x8(lm);
                e.right_sample = saturate_x8(rm);
            end
        endcase
        mix_expected.push_back(e);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_word(logic [1:0] op, int addr, int data);
        pending_word_t p;
        p.w.opcode = op;
        p.w.address = addr[19:0];
        p.w.write_data = data[7:0];
        p.drain = next_drain;
        next_drain = 0;
        words_to_send.push_back(p);
        words_queued++;
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    // loads the rom window the voice can reach, then programs and keys it on
    task automatic keyon_sequence(int v, int fill);
        int r, bank, start, len, stop, loopa, adrs, base, lo, hi, freq;
        r = v * 16;
        bank = $urandom_range(0, 255);
        start = $urandom_range(8, 65500);
        if ($urandom_range(0, 7) == 0)
        begin
            // end before start: the voice hits its end on its first tick unless its frequency is zero
            stop = start - $urandom_range(1, 3);
            loopa = start + $urandom_range(0, 8) - 4;
            lo = -4;
            hi = 8;
        end
        else
        begin
            len = $urandom_range(0, 12);
            stop = start + len;
            loopa = start + $urandom_range(0, len + 8) - 4;
            lo = -4;
            hi = len + 5;
        end
        adrs = (bank << 16) + start;
        base = ((adrs & 'h200000) >> 2) | (adrs & 'h7ffff);
        for (int k = lo; k <= hi; k++)
            queue_word(OP_LOAD, (base + k) | ($urandom_range(0, 1) << 20),
                       fill < 0 ? $urandom_range(0, 255) : fill);
        case ($urandom_range(0, 3))
            0: freq = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255);
            1: freq = $urandom_range(256, 32767);
            default: freq = $urandom_range(32768, 65535);
        endcase
        if (fill >= 0)
            freq = 'hffff;
        queue_word(OP_WRITE, r + REG_BANK, bank);
        queue_word(OP_WRITE, r + 6, start >> 8);
        queue_word(OP_WRITE, r + 7, start);
        queue_word(OP_WRITE, r + 8, stop >> 8);
        queue_word(OP_WRITE, r + 9, stop);
        queue_word(OP_WRITE, r + 10, loopa >> 8);
        queue_word(OP_WRITE, r + 11, loopa);
        queue_word(OP_WRITE, r + 0, fill < 0 ? $urandom_range(0, 255) : 255);
        queue_word(OP_WRITE, r + 1, fill < 0 ? $urandom_range(0, 255) : 255);
        queue_word(OP_WRITE, r + 2, freq >> 8);
        queue_word(OP_WRITE, r + 3, freq);
        queue_word(OP_WRITE, r + REG_MODE + ($urandom_range(0, 2047) << 9),
                   'h80 | $urandom_range(0, 127));
        keyons_sent++;
    endtask

    task automatic queue_safe_write();
        int addr, data;
        addr = $urandom_range(0, 'hfffff);
        data = $urandom_range(0, 255);
        // keep random writes from keying a voice on with unprepared pointers
        if ((addr & 'h1ff) < REG_VOICE_LIMIT && (addr & 15) == REG_MODE)
            data = data & 'h7f;
        queue_word(OP_WRITE, addr, data);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sender: bursts of words with random gaps, pausing at drain points
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.payload <= '0;
            gap_left <= 0;
            burst_left <= 4;
        end
        else if (!(req.valid && !req.ready))
        begin
            if (req.valid)
            begin
                mix_predict(req.payload);
                void'(words_to_send.pop_front());
                words_accepted++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (words_to_send.size() > 0 &&
                     !(words_to_send[0].drain && mix_expected.size() > 0))
            begin
                req.valid <= 1'b1;
                req.payload <= words_to_send[0].w;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // receiver: rotating stall patterns plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left = 0;
            hold_done = 0;
            ready_cycle = 0;
        end
        else
        begin
            ready_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (!hold_done && words_accepted >= HOLD_AFTER)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                rsp.ready <= 1'b0;
            end
            else
            begin
                case ((ready_cycle >> 8) % 4)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= $urandom_range(0, 1);
                    2: rsp.ready <= $urandom_range(0, 7) != 0;
                    default: rsp.ready <= ready_cycle[2];
                endcase
            end
        end
    end

    // monitor: each accepted word against the oldest prediction
    always @(posedge clk)
    begin
        rsp_word_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (rsp.payload.left_sample == 16'sh7fff || rsp.payload.left_sample == -16'sh8000)
                saturated_seen++;
            if (mix_expected.size() == 0)
                report_mismatch("unexpected word, read_data", rsp.payload.read_data, -1);
            else
            begin
                e = mix_expected.pop_front();
                if (rsp.payload.read_data !== e.read_data)
                    report_mismatch("read_data", rsp.payload.read_data, e.read_data);
                if (rsp.payload.left_sample !== e.left_sample)
                    report_mismatch("left_sample", rsp.payload.left_sample, e.left_sample);
                if (rsp.payload.right_sample !== e.right_sample)
                    report_mismatch("right_sample", rsp.payload.right_sample, e.right_sample);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        idle_cycles = 0;
        next_drain = 0;

        // directed part
        queue_word(OP_READ, 'h005, 0);
        queue_word(OP_WRITE, 'h1ff, 'hff);
        queue_word(OP_READ, 'hfffff, 0);
        queue_word(OP_WRITE, 'h185, 'h98);
        queue_word(OP_READ, 'h185, 0);
        queue_word(OP_TICK, 0, 0);
        queue_word(OP_LOAD, 'h00000, 'h00);
        queue_word(OP_LOAD, 'hfffff, 'hff);
        keyon_sequence(0, -1);
        keyon_sequence(NUM_VOICES - 1, -1);
        for (int v = 1; v <= 4; v++)
            keyon_sequence(v, 'h7f);
        repeat (6) queue_word(OP_TICK, 0, 0);
        for (int v = 1; v <= 4; v++)
            queue_word(OP_WRITE, v * 16 + REG_MODE, 'h00);
        for (int v = 5; v <= 8; v++)
            keyon_sequence(v, 'h80);
        repeat (6) queue_word(OP_TICK, 0, 0);
        queue_word(OP_WRITE, (NUM_VOICES - 1) * 16 + 2, 0);
        queue_word(OP_WRITE, (NUM_VOICES - 1) * 16 + 3, 0);
        queue_word(OP_TICK, 0, 0);
        next_drain = 1;

        // random part
        while (words_queued < 1100)
        begin
            case ($urandom_range(0, 19))
                0, 1: keyon_sequence($urandom_range(0, NUM_VOICES - 1), -1);
                2, 3, 4, 5, 6, 7, 8: repeat ($urandom_range(1, 8)) queue_word(OP_TICK, 0, 0);
                9, 10: queue_safe_write();
                11, 12: queue_word(OP_READ, $urandom_range(0, 'hfffff), $urandom_range(0, 255));
                13: queue_word(OP_LOAD, $urandom_range(0, 'hfffff), $urandom_range(0, 255));
                14: queue_word(OP_WRITE, $urandom_range(0, NUM_VOICES - 1) * 16 + REG_MODE,
                               $urandom_range(0, 127));
                15, 16: queue_word(OP_WRITE,
                                   $urandom_range(0, NUM_VOICES - 1) * 16 + $urandom_range(0, 3),
                                   $urandom_range(0, 255));
                17: queue_word(OP_READ, $urandom_range(0, 'h17f), 0);
                default: next_drain = 1;
            endcase
        end
        queue_word(OP_TICK, 0, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_to_send.size() > 0 || req.valid || mix_expected.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("covered %0d words: %0d ticks, %0d voice key-ons, %0d results checked",
                 words_accepted, ticks_sent, keyons_sent, results_seen);
        $display("saturated left mixes seen: %0d, mismatches: %0d", saturated_seen, mismatches);
        if (mismatches == 0 && mix_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== multivoice_pcm_sample_mixer_unit.f =====
rtl/mpsm_pkg.sv
rtl/mpsm_req_if.sv
rtl/mpsm_ram.sv
rtl/multivoice_pcm_sample_mixer_unit.sv
bench/multivoice_pcm_sample_mixer_unit_tb.sv
